[hdl/timestamp_sorted_event_queue_defines.svh]
// ---------------------------------------------------------------------------
// timestamp sorted event queue: assertion macros
// shared wrappers for the concurrent checks on the queue ports
// ---------------------------------------------------------------------------
`ifndef TIMESTAMP_SORTED_EVENT_QUEUE_DEFINES_SVH
`define TIMESTAMP_SORTED_EVENT_QUEUE_DEFINES_SVH

// check gated off while reset is applied
`define TSEQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also runs through reset
`define TSEQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/tseq_pkg.sv]
// ---------------------------------------------------------------------------
// tseq_pkg
// types and constants shared by the event queue modules
// ---------------------------------------------------------------------------
package tseq_pkg;

  localparam int TIME_W = 48;
  localparam int BYTE_W = 8;

  // request codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_FIRE   = 1'b1;

  // request queue between front and back: 2**CMD_PTR_W slots
  localparam int CMD_PTR_W = 1;

  typedef struct packed {
    logic              opcode;
    logic [TIME_W-1:0] event_time;
    logic [BYTE_W-1:0] status_byte;
    logic [BYTE_W-1:0] first_data;
    logic [BYTE_W-1:0] second_data;
    logic              bypass_flag;
  } cmd_t;

  typedef struct packed {
    logic [TIME_W-1:0] due_time;
    logic [BYTE_W-1:0] status_byte;
    logic [BYTE_W-1:0] first_data;
    logic [BYTE_W-1:0] second_data;
    logic              bypass_flag;
  } entry_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] status_byte;
    logic [BYTE_W-1:0] first_data;
    logic [BYTE_W-1:0] second_data;
    logic              bypass_flag;
    logic              last_of_run;
  } res_t;

endpackage

[hdl/tseq_cmd_fifo.sv]
// ---------------------------------------------------------------------------
// tseq_cmd_fifo
// front end: takes requests and queues them for the cell array
// ---------------------------------------------------------------------------
module tseq_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tseq_pkg::cmd_t push_cmd,
  output logic          full,
  output logic          cmd_valid,
  output tseq_pkg::cmd_t cmd,
  input  logic          pop
);

  localparam int PW    = tseq_pkg::CMD_PTR_W;
  localparam int SLOTS = 2 ** PW;

  tseq_pkg::cmd_t slots_r [SLOTS];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]    fill_r, fill_nxt;
  logic           do_push, do_pop;

  assign full      = (fill_r == (PW+1)'(SLOTS));
  assign cmd_valid = (fill_r != '0);
  assign cmd       = slots_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && cmd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PW'(do_push);
    rd_ptr_nxt = rd_ptr_r + PW'(do_pop);
    fill_nxt   = fill_r + (PW+1)'(do_push) - (PW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[hdl/tseq_event_cells.sv]
// ---------------------------------------------------------------------------
// tseq_event_cells
// back end: sorted shifting cell array, carries out insert and fire
// ---------------------------------------------------------------------------
module tseq_event_cells #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  tseq_pkg::cmd_t cmd,
  output logic           pop,
  output tseq_pkg::res_t res
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_FIRE = 1'b1;

  tseq_pkg::entry_t cells_r [QUEUE_DEPTH];
  tseq_pkg::entry_t cells_nxt [QUEUE_DEPTH];
  tseq_pkg::entry_t new_entry;
  logic [QUEUE_DEPTH-1:0]    le;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic                      state_r, state_nxt;
  logic [tseq_pkg::TIME_W-1:0] now_r, now_nxt;
  tseq_pkg::res_t            res_r, res_nxt;
  logic                      head_due, next_due, do_insert;

  assign new_entry = '{due_time:    cmd.event_time,
                       status_byte: cmd.status_byte,
                       first_data:  cmd.first_data,
                       second_data: cmd.second_data,
                       bypass_flag: cmd.bypass_flag};

  // cells at or before the new time, a prefix of the held run
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      le[i] = (CNT_W'(i) < count_r) && (cells_r[i].due_time <= cmd.event_time);
    end
  end

  assign head_due  = (count_r != '0) && (cells_r[0].due_time <= now_r);
  assign next_due  = (count_r > CNT_W'(1)) && (cells_r[1].due_time <= now_r);
  assign pop       = cmd_valid && (state_r == ST_IDLE);
  assign do_insert = pop && (cmd.opcode == tseq_pkg::OP_INSERT)
                     && (count_r != CNT_W'(QUEUE_DEPTH));

  always_comb begin
    cells_nxt = cells_r;
    count_nxt = count_r;
    state_nxt = state_r;
    now_nxt   = now_r;
    res_nxt   = res_r;
    res_nxt.valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (do_insert) begin
          if (!le[0]) begin
            cells_nxt[0] = new_entry;
          end
          for (int i = 1; i < QUEUE_DEPTH; i++) begin
            if (!le[i]) begin
              cells_nxt[i] = le[i-1] ? new_entry : cells_r[i-1];
            end
          end
          count_nxt = count_r + CNT_W'(1);
        end else if (pop && (cmd.opcode == tseq_pkg::OP_FIRE)) begin
          now_nxt   = cmd.event_time;
          state_nxt = ST_FIRE;
        end
      end
      ST_FIRE: begin
        if (head_due) begin
          res_nxt.valid       = 1'b1;
          res_nxt.status_byte = cells_r[0].status_byte;
          res_nxt.first_data  = cells_r[0].first_data;
          res_nxt.second_data = cells_r[0].second_data;
          res_nxt.bypass_flag = cells_r[0].bypass_flag;
          res_nxt.last_of_run = !next_due;
          for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            cells_nxt[i] = cells_r[i+1];
          end
          count_nxt = count_r - CNT_W'(1);
          if (!next_due) begin
            state_nxt = ST_IDLE;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      state_r     <= ST_IDLE;
      res_r.valid <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      state_r     <= state_nxt;
      res_r.valid <= res_nxt.valid;
    end
    res_r.status_byte <= res_nxt.status_byte;
    res_r.first_data  <= res_nxt.first_data;
    res_r.second_data <= res_nxt.second_data;
    res_r.bypass_flag <= res_nxt.bypass_flag;
    res_r.last_of_run <= res_nxt.last_of_run;
  end

  always_ff @(posedge clk) begin
    cells_r <= cells_nxt;
    now_r   <= now_nxt;
  end

  assign res = res_r;

endmodule

[hdl/timestamp_sorted_event_queue.sv]
// ---------------------------------------------------------------------------
// timestamp_sorted_event_queue
// time ordered queue of three-byte midi events with insert and fire requests
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy rises only
// when both slots of the two-deep request queue are occupied. Results appear
// on the out_ ports for one cycle each, marked by out_valid, and cannot be
// held off. An insert is carried out once it reaches the head of the
// request queue while no fire is running and gives no result; on a full
// queue it is dropped. A fire first loads the time and then sends out its
// due events, oldest first on consecutive cycles with
// out_last_of_run on the final one; a fire with nothing due gives no
// result and goes back to idle on finding the head not due. Every step of
// that work is one step of the sorted cell array, which holds all
// QUEUE_DEPTH events in registers and compares every cell against an
// insert's time in parallel. Requests keep their order.
// ---------------------------------------------------------------------------
module timestamp_sorted_event_queue #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_opcode,
  input  logic [47:0] in_event_time,
  input  logic [7:0]  in_status_byte,
  input  logic [7:0]  in_first_data,
  input  logic [7:0]  in_second_data,
  input  logic        in_bypass_flag,
  output logic        out_valid,
  output logic [7:0]  out_status,
  output logic [7:0]  out_first,
  output logic [7:0]  out_second,
  output logic        out_bypass,
  output logic        out_last_of_run
);

  tseq_pkg::cmd_t in_cmd;    // request as presented on the ports
  tseq_pkg::cmd_t head_cmd;  // oldest queued request
  tseq_pkg::res_t res;       // registered result from the cell array
  logic           head_valid;
  logic           head_pop;

  assign in_cmd = '{opcode:      in_opcode,
                    event_time:  in_event_time,
                    status_byte: in_status_byte,
                    first_data:  in_first_data,
                    second_data: in_second_data,
                    bypass_flag: in_bypass_flag};

  // front end: request queue, lets the host post while a fire is running
  tseq_cmd_fifo u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (start),
    .push_cmd  (in_cmd),
    .full      (busy),
    .cmd_valid (head_valid),
    .cmd       (head_cmd),
    .pop       (head_pop)
  );

  // back end: sorted cells, one insert or one fire step per cycle
  tseq_event_cells #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (head_valid),
    .cmd       (head_cmd),
    .pop       (head_pop),
    .res       (res)
  );

  // results straight from the output register
  assign out_valid       = res.valid;
  assign out_status      = res.status_byte;
  assign out_first       = res.first_data;
  assign out_second      = res.second_data;
  assign out_bypass      = res.bypass_flag;
  assign out_last_of_run = res.last_of_run;

endmodule

[hdl/tseq_checker.sv]
// ---------------------------------------------------------------------------
// tseq_checker
// port level checks on the event queue, bound to the top level
// ---------------------------------------------------------------------------
`include "timestamp_sorted_event_queue_defines.svh"

module tseq_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic out_last_of_run
);

  // reset leaves no result pending and the request queue empty
  `TSEQ_ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> (!out_valid && !busy), "reset not clean")

  // a fire run keeps going without gaps until its last event
  `TSEQ_ASSERT(a_run_unbroken, clk, rst_n, (out_valid && !out_last_of_run) |=> out_valid, "run broken")

  // the request queue only fills when a request is offered
  `TSEQ_ASSERT(a_busy_cause, clk, rst_n, $rose(busy) |-> $past(start), "busy without request")

endmodule

bind timestamp_sorted_event_queue tseq_checker u_tseq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_last_of_run (out_last_of_run)
);
